@@ rtl/arr_pkg.sv @@
// ----------------------------------------------------------------------------
// arr_pkg
// Shared types and constants of the anti-aliased ring rasterizer.
// ----------------------------------------------------------------------------
package arr_pkg;

    localparam int COORD_W    = 6;
    localparam int SIDE_W     = 7;
    localparam int HALF_W     = 8;
    localparam int SQ_W       = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECTED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COLOR = 3'd5;

    typedef struct packed {
        logic [SIDE_W-1:0]  side_w;
        logic [SIDE_W-1:0]  side_h;
        logic               sel;
        logic [COLOR_W-1:0] back;
        logic [COLOR_W-1:0] ring;
    } t_cfg;

    typedef enum logic [2:0] {
        RG_BACK,
        RG_OUTER_EDGE,
        RG_RING,
        RG_INNER_EDGE,
        RG_FILL
    } t_region;

endpackage

@@ rtl/arr_dist.sv @@
// ----------------------------------------------------------------------------
// arr_dist
// Offset distances from the tile centre and their sum of squares, scaled
// into the square root radicand. Two register stages.
// ----------------------------------------------------------------------------
module arr_dist #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  arr_pkg::t_cfg                          i_cfg,
    input  logic                                   i_valid,
    input  logic [arr_pkg::COORD_W-1:0]            i_x,
    input  logic [arr_pkg::COORD_W-1:0]            i_y,
    output logic                                   o_valid,
    output logic [arr_pkg::SQ_W+2*FRAC_BITS-3:0]   o_rad
);
    import arr_pkg::*;

    logic [SIDE_W-1:0] n_px2;
    logic [SIDE_W-1:0] n_py2;
    logic [HALF_W-1:0] n_hx;
    logic [HALF_W-1:0] n_hy;
    logic [HALF_W-1:0] r_hx;
    logic [HALF_W-1:0] r_hy;
    logic              r_valid1;
    logic [SQ_W-1:0]   n_sum;
    logic [SQ_W-1:0]   r_sum;
    logic              r_valid2;

    always_comb begin
        n_px2 = {i_x, 1'b0};
        n_py2 = {i_y, 1'b0};
        if (n_px2 >= i_cfg.side_w) begin
            n_hx = {1'b0, n_px2} - {1'b0, i_cfg.side_w} + 8'd2;
        end else begin
            n_hx = {1'b0, i_cfg.side_w} - {1'b0, n_px2};
        end
        if (n_py2 >= i_cfg.side_h) begin
            n_hy = {1'b0, n_py2} - {1'b0, i_cfg.side_h} + 8'd2;
        end else begin
            n_hy = {1'b0, i_cfg.side_h} - {1'b0, n_py2};
        end
        n_sum = (r_hx * r_hx) + (r_hy * r_hy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hx  <= n_hx;
            r_hy  <= n_hy;
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid2;
    assign o_rad   = {r_sum, {(2*FRAC_BITS-2){1'b0}}};

endmodule

@@ rtl/arr_sqrt.sv @@
// ----------------------------------------------------------------------------
// arr_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module arr_sqrt #(
    parameter int ROOT_W = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root
);
    logic                r_valid [ROOT_W];
    logic [2*ROOT_W-1:0] r_rad   [ROOT_W];
    logic [ROOT_W:0]     r_rem   [ROOT_W];
    logic [ROOT_W-1:0]   r_root  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                st_valid;
        logic [2*ROOT_W-1:0] st_rad;
        logic [ROOT_W:0]     st_rem;
        logic [ROOT_W-1:0]   st_root;
        logic [ROOT_W+2:0]   n_r2;
        logic [ROOT_W+2:0]   n_trial;
        logic                n_ge;
        logic [ROOT_W+2:0]   n_diff;

        if (k == 0) begin : g_first
            assign st_valid = i_valid;
            assign st_rad   = i_rad;
            assign st_rem   = '0;
            assign st_root  = '0;
        end else begin : g_next
            assign st_valid = r_valid[k-1];
            assign st_rad   = r_rad[k-1];
            assign st_rem   = r_rem[k-1];
            assign st_root  = r_root[k-1];
        end

        always_comb begin
            n_r2    = {st_rem, st_rad[2*ROOT_W-1 -: 2]};
            n_trial = {1'b0, st_root, 2'b01};
            n_ge    = (n_r2 >= n_trial);
            n_diff  = n_r2 - n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= st_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {st_rad[2*ROOT_W-3:0], 2'b00};
                r_rem[k]  <= n_ge ? n_diff[ROOT_W:0] : n_r2[ROOT_W:0];
                r_root[k] <= {st_root[ROOT_W-2:0], n_ge};
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

@@ rtl/arr_shade.sv @@
// ----------------------------------------------------------------------------
// arr_shade
// Region decision, blend weight, channel blend and division by 255.
// Four register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module arr_shade #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  arr_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    input  logic [FRAC_BITS+6:0]           i_dis,
    output logic                           o_valid,
    output logic [arr_pkg::COLOR_W-1:0]    o_color
);
    import arr_pkg::*;

    localparam int ROOT_W   = FRAC_BITS + 7;
    localparam int SW       = ROOT_W + 2;
    localparam int REM_W    = FRAC_BITS + 1;
    localparam int WID_THIN = ((13 << FRAC_BITS) + 5) / 10;
    localparam logic signed [SW-1:0] ONE    = SW'(1 << FRAC_BITS);
    localparam logic signed [SW-1:0] THIN_W = SW'(WID_THIN);

    // stage 1: region
    logic signed [SW-1:0] n_dis;
    logic signed [SW-1:0] n_rout;
    logic signed [SW-1:0] n_rin;
    logic signed [SW-1:0] n_wid;
    logic signed [SW-1:0] n_diff;
    logic [SIDE_W:0]      n_q;
    logic [2:0]           n_qmin;
    t_region              n_region;
    t_region              r1_region;
    logic [REM_W-1:0]     r1_rem;
    logic                 r1_valid;

    // stage 2: weight and color selection
    logic [REM_W+7:0]     n_wprod;
    logic [8:0]           n_caraw;
    logic [CHAN_W-1:0]    n_ca;
    logic [CHAN_W-1:0]    n_cas;
    logic [COLOR_W-1:0]   n_c0;
    logic [COLOR_W-1:0]   n_c1;
    logic [CHAN_W-1:0]    r2_ca;
    logic [CHAN_W-1:0]    r2_a;
    logic [COLOR_W-1:0]   r2_c0;
    logic [COLOR_W-1:0]   r2_c1;
    logic                 r2_valid;

    // stage 3: products
    logic [16:0]          n_sum  [3];
    logic [15:0]          r3_sum [3];
    logic                 r3_valid;

    // stage 4: divide by 255
    logic [16:0]          n_t    [3];
    logic [COLOR_W-1:0]   n_out;
    logic [COLOR_W-1:0]   r4_out;
    logic                 r4_valid;

    always_comb begin
        n_dis  = signed'({2'b00, i_dis});
        n_rout = signed'(SW'(i_cfg.side_h[SIDE_W-1:1]) << FRAC_BITS);
        n_q    = ({1'b0, i_cfg.side_w} + 8'd3) >> 2;
        n_qmin = (n_q > 8'd4) ? 3'd4 : n_q[2:0];
        n_wid  = i_cfg.sel ? signed'(SW'(n_qmin) << FRAC_BITS) : THIN_W;
        n_rin  = n_rout - n_wid;
        n_diff = n_dis - n_rout;
        if (i_cfg.side_w == '0 || i_cfg.side_h == '0) begin
            n_region = RG_BACK;
        end else if (n_dis < n_rout + ONE) begin
            if (n_dis <= n_rout) begin
                if (n_dis <= n_rin + ONE) begin
                    if (n_dis <= n_rin) begin
                        n_region = RG_FILL;
                    end else begin
                        n_region = RG_INNER_EDGE;
                        n_diff   = n_dis - n_rin;
                    end
                end else begin
                    n_region = RG_RING;
                end
            end else begin
                n_region = RG_OUTER_EDGE;
            end
        end else begin
            n_region = RG_BACK;
        end
    end

    always_comb begin
        n_wprod = {8'b0, r1_rem} * {{REM_W{1'b0}}, 8'hff};
        n_caraw = n_wprod[REM_W+7:FRAC_BITS];
        n_ca    = (n_caraw > 9'd255) ? 8'hff : n_caraw[7:0];
        n_c0    = i_cfg.back;
        n_c1    = i_cfg.back;
        n_cas   = '0;
        case (r1_region)
            RG_OUTER_EDGE: begin
                n_c0  = i_cfg.ring;
                n_c1  = i_cfg.back;
                n_cas = n_ca;
            end
            RG_INNER_EDGE: begin
                n_c0  = i_cfg.back;
                n_c1  = i_cfg.ring;
                n_cas = n_ca;
            end
            RG_RING: begin
                n_c0 = i_cfg.ring;
            end
            default: begin
                n_c0 = i_cfg.back;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = {1'b0, {8'b0, r2_a} * {8'b0, r2_c0[8*k +: 8]}}
                     + {1'b0, {8'b0, r2_ca} * {8'b0, r2_c1[8*k +: 8]}};
            n_t[k]   = {1'b0, r3_sum[k]} + {9'b0, r3_sum[k][15:8]} + 17'd1;
            n_out[8*k +: 8] = n_t[k][15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_region <= n_region;
            r1_rem    <= n_diff[REM_W-1:0];
            r2_ca     <= n_cas;
            r2_a      <= 8'hff - n_cas;
            r2_c0     <= n_c0;
            r2_c1     <= n_c1;
            for (int k = 0; k < 3; k++) begin
                r3_sum[k] <= n_sum[k][15:0];
            end
            r4_out    <= n_out;
        end
    end

    assign o_valid = r4_valid;
    assign o_color = r4_out;

endmodule

@@ rtl/antialiased_ring_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// antialiased_ring_rasterizer_unit
// Renders one pixel of an anti-aliased ring per clock for a configured tile, while the receiver does not stall.
//
// The slave stream takes one pixel coordinate per transaction (tdata: column
// in the lowest six bits, row above it). The master stream gives one color
// per transaction (tdata: blue, green, red from the lowest byte up), in the
// order the coordinates came in. A full pipeline accepts one pixel every
// clock while the receiver takes results; the pipeline holds two distance
// stages, FRAC_BITS + 7 square root stages (one root bit per stage) and four
// shading stages. Registers are written through the plain write port; the
// user must write them only while no pixel is in flight, the block itself
// does not enforce it. Reset clears the pipeline valid bits and loads the
// register reset values (16 by 16 tile, thin ring, black colors).
// When the receiver stalls, the whole pipeline holds and o_s_axis_tready drops
// once the output register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module antialiased_ring_rasterizer_unit #(
    parameter int MAX_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [arr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [arr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [15:0]                        i_s_axis_tdata,  // pixel_x, pixel_y
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [23:0]                        o_m_axis_tdata   // out_blue, out_green, out_red
);
    import arr_pkg::*;

    localparam int ROOT_W = FRAC_BITS + 7;

    logic [SIDE_W-1:0]   r_tile_width;
    logic [SIDE_W-1:0]   r_tile_height;
    logic                r_selected;
    logic [COLOR_W-1:0]  r_back_color;
    logic [COLOR_W-1:0]  r_border_color;
    logic [COLOR_W-1:0]  r_normal_color;

    t_cfg                cfg;
    logic                en;
    logic                dist_valid;
    logic [2*ROOT_W-1:0] dist_rad;
    logic                sqrt_valid;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                shade_valid;
    logic [COLOR_W-1:0]  shade_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width   <= 7'd16;
            r_tile_height  <= 7'd16;
            r_selected     <= 1'b0;
            r_back_color   <= '0;
            r_border_color <= '0;
            r_normal_color <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TILE_WIDTH:   r_tile_width   <= i_cfg_data[SIDE_W-1:0];
                REG_TILE_HEIGHT:  r_tile_height  <= i_cfg_data[SIDE_W-1:0];
                REG_SELECTED:     r_selected     <= i_cfg_data[0];
                REG_BACK_COLOR:   r_back_color   <= i_cfg_data[COLOR_W-1:0];
                REG_BORDER_COLOR: r_border_color <= i_cfg_data[COLOR_W-1:0];
                REG_NORMAL_COLOR: r_normal_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.side_w = ({25'b0, r_tile_width} > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_tile_width;
        cfg.side_h = ({25'b0, r_tile_height} > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_tile_height;
        cfg.sel    = r_selected;
        cfg.back   = r_back_color;
        cfg.ring   = r_selected ? r_border_color : r_normal_color;
    end

    assign en              = !shade_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    arr_dist #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[5:0]),
        .i_y     (i_s_axis_tdata[11:6]),
        .o_valid (dist_valid),
        .o_rad   (dist_rad)
    );

    arr_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dist_valid),
        .i_rad   (dist_rad),
        .o_valid (sqrt_valid),
        .o_root  (sqrt_root)
    );

    arr_shade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (sqrt_valid),
        .i_dis   (sqrt_root),
        .o_valid (shade_valid),
        .o_color (shade_color)
    );

    assign o_m_axis_tvalid = shade_valid;
    assign o_m_axis_tdata  = shade_color;

endmodule

@@ sim/arr_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arr_pixel_checker
// Watches the register port and both pixel streams of the ring rasterizer.
// Keeps a mirror of the tile registers and shades every accepted coordinate
// on its own. The colours are held in arrival order, and each colour
// transaction is compared channel by channel with the oldest one held.
// ----------------------------------------------------------------------------
module arr_pixel_checker #(
    parameter int MAX_SIDE  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [arr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [15:0]                    i_pix_data,   // pixel_x, pixel_y
    input  logic                           i_rgb_valid,
    input  logic                           i_rgb_ready,
    input  logic [23:0]                    i_rgb_data,   // out_blue, out_green, out_red
    output int                             o_fail_count,
    output int                             o_pending
);
    import arr_pkg::*;

    localparam int PRINT_CAP = 60;

    logic [SIDE_W-1:0]  tile_w;
    logic [SIDE_W-1:0]  tile_h;
    logic               thick_ring;
    logic [COLOR_W-1:0] back_rgb;
    logic [COLOR_W-1:0] border_rgb;
    logic [COLOR_W-1:0] normal_rgb;
    logic [23:0]        expected_rgb[$];
    int                 results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] result %0d, %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
        o_fail_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // distance from the tile centre in half pixels, one pixel added past it
    function automatic longint unsigned axis_offset(input longint unsigned p,
                                                    input longint unsigned side);
        if (2 * p >= side)
            return 2 * p - side + 2;
        return side - 2 * p;
    endfunction

    function automatic int edge_weight(input longint rem);
        longint unsigned r;
        longint unsigned ca;
        r  = (rem < 0) ? 0 : rem;
        ca = (r * 255) >> FRAC_BITS;
        return (ca > 255) ? 255 : int'(ca);
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] c0, input logic [23:0] c1,
                                            input int ca);
        logic [23:0] res;
        int          a;
        a = 255 - ca;
        for (int k = 0; k < 3; k++)
            res[8*k +: 8] = 8'((a * int'(c0[8*k +: 8]) + ca * int'(c1[8*k +: 8])) / 255);
        return res;
    endfunction

    function automatic logic [23:0] shade_pixel(input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py);
        longint unsigned w;
        longint unsigned h;
        longint unsigned hx;
        longint unsigned hy;
        longint unsigned q;
        longint          one;
        longint          dis;
        longint          r_out;
        longint          r_in;
        longint          wid;
        logic [23:0]     ring;
        w   = (tile_w > MAX_SIDE) ? MAX_SIDE : tile_w;
        h   = (tile_h > MAX_SIDE) ? MAX_SIDE : tile_h;
        one = longint'(1) << FRAC_BITS;
        if (w == 0 || h == 0)
            return back_rgb;
        hx    = axis_offset(px, w);
        hy    = axis_offset(py, h);
        dis   = longint'(int_sqrt((hx * hx + hy * hy) << (2 * FRAC_BITS - 2)));
        r_out = longint'(h >> 1) << FRAC_BITS;
        if (thick_ring) begin
            q    = (w + 3) / 4;
            wid  = longint'((q < 4) ? q : 4) << FRAC_BITS;
            ring = border_rgb;
        end else begin
            wid  = ((longint'(13) << FRAC_BITS) + 5) / 10;
            ring = normal_rgb;
        end
        r_in = r_out - wid;
        if (dis >= r_out + one)
            return back_rgb;
        if (dis > r_out)
            return mix_rgb(ring, back_rgb, edge_weight(dis - r_out));
        if (dis > r_in + one)
            return ring;
        if (dis > r_in)
            return mix_rgb(back_rgb, ring, edge_weight(dis - r_in));
        return back_rgb;
    endfunction

    always @(posedge i_clk) begin
        logic [23:0] want;
        if (!i_rst_n) begin
            tile_w     = 7'd16;
            tile_h     = 7'd16;
            thick_ring = 1'b0;
            back_rgb   = '0;
            border_rgb = '0;
            normal_rgb = '0;
            expected_rgb.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TILE_WIDTH:   tile_w     = i_cfg_data[SIDE_W-1:0];
                    REG_TILE_HEIGHT:  tile_h     = i_cfg_data[SIDE_W-1:0];
                    REG_SELECTED:     thick_ring = i_cfg_data[0];
                    REG_BACK_COLOR:   back_rgb   = i_cfg_data[COLOR_W-1:0];
                    REG_BORDER_COLOR: border_rgb = i_cfg_data[COLOR_W-1:0];
                    REG_NORMAL_COLOR: normal_rgb = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready)
                expected_rgb.push_back(shade_pixel(i_pix_data[5:0], i_pix_data[11:6]));
            if (i_rgb_valid && i_rgb_ready) begin
                if (expected_rgb.size() == 0) begin
                    report_mismatch("colour with no pixel pending", int'(i_rgb_data), 0);
                end else begin
                    want = expected_rgb.pop_front();
                    if (i_rgb_data[7:0] !== want[7:0])
                        report_mismatch("out_blue", int'(i_rgb_data[7:0]), int'(want[7:0]));
                    if (i_rgb_data[15:8] !== want[15:8])
                        report_mismatch("out_green", int'(i_rgb_data[15:8]),
                                        int'(want[15:8]));
                    if (i_rgb_data[23:16] !== want[23:16])
                        report_mismatch("out_red", int'(i_rgb_data[23:16]),
                                        int'(want[23:16]));
                end
                results_seen++;
            end
        end
        o_pending <= expected_rgb.size();
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the anti-aliased ring rasterizer.
// Runs a series of tile settings (reset values, full and oversized tiles,
// empty tiles, one-pixel and odd-sized tiles, thin and thick rings, black
// and white colours) with a few probe pixels and random coordinates biased
// into the tile. The sender works in bursts, the receiver stalls on its own
// pattern; one long receiver hold-off and one full drain in mid-phase are included.
// ----------------------------------------------------------------------------
module tb;
    import arr_pkg::*;

    localparam int MAX_SIDE    = 64;
    localparam int FRAC_BITS   = 8;
    localparam int PIPE_LAT    = FRAC_BITS + 13;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 78;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int HOLD_PHASE  = 3;
    localparam int PAUSE_PHASE = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pix_valid;
    logic                  pix_ready;
    logic [15:0]           pix_data;
    logic                  rgb_valid;
    logic                  rgb_ready;
    logic [23:0]           rgb_data;
    int                    fail_count;
    int                    pending_count;

    int  burst_left = 4;
    bit  tx_gappy   = 1'b0;
    int  rx_mode    = 0;
    bit  hold_request = 1'b0;
    int unsigned cur_w = 16;
    int unsigned cur_h = 16;

    int unsigned side_w_tbl[PHASES] = '{16, 16, 64, 127, 1, 0, 16, 3, 64, 8, 0, 0};
    int unsigned side_h_tbl[PHASES] = '{16, 16, 64, 100, 1, 16, 0, 5, 8, 64, 0, 0};
    bit          thick_tbl[PHASES]  = '{0, 0, 1, 0, 1, 0, 1, 1, 0, 1, 0, 0};

    antialiased_ring_rasterizer_unit #(
        .MAX_SIDE (MAX_SIDE),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(pix_valid),
        .o_s_axis_tready(pix_ready),
        .i_s_axis_tdata (pix_data),
        .o_m_axis_tvalid(rgb_valid),
        .i_m_axis_tready(rgb_ready),
        .o_m_axis_tdata (rgb_data)
    );

    arr_pixel_checker #(
        .MAX_SIDE (MAX_SIDE),
        .FRAC_BITS(FRAC_BITS)
    ) pixel_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .i_pix_data  (pix_data),
        .i_rgb_valid (rgb_valid),
        .i_rgb_ready (rgb_ready),
        .i_rgb_data  (rgb_data),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((pix_valid && pix_ready) || (rgb_valid && rgb_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : receiver
        rgb_ready <= 1'b1;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                rgb_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_mode == 0) begin
                rgb_ready <= 1'b1;
                @(posedge clk);
            end else if (rx_mode == 1) begin
                rgb_ready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rgb_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                rgb_ready <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        pix_valid <= 1'b1;
        pix_data  <= {4'b0000, row, col};
        do @(posedge clk); while (!pix_ready);
        if (tx_gappy) begin
            burst_left--;
            if (burst_left <= 0) begin
                pix_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    task automatic drain_pixels();
        pix_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // mostly inside the tile, sometimes anywhere in the coordinate range
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned side);
        int unsigned lim;
        lim = (side == 0 || side > MAX_SIDE) ? MAX_SIDE : side;
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom_range(0, 63));
        return COORD_W'($urandom_range(0, lim - 1));
    endfunction

    initial begin : stimulus
        int unsigned back_c;
        int unsigned border_c;
        int unsigned normal_c;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_TILE_WIDTH;
        cfg_data  <= '0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            rx_mode  = phase % 3;
            tx_gappy = (phase % 4) != 0;
            if (phase > 0) begin
                drain_pixels();
                cur_w = side_w_tbl[phase];
                cur_h = side_h_tbl[phase];
                if (phase >= 10) begin
                    cur_w = $urandom_range(1, 64);
                    cur_h = $urandom_range(1, 64);
                end
                back_c   = $urandom_range(0, 24'hffffff);
                border_c = $urandom_range(0, 24'hffffff);
                normal_c = $urandom_range(0, 24'hffffff);
                if (phase == 2) begin
                    back_c   = 24'h000000;
                    border_c = 24'hffffff;
                    normal_c = 24'hffffff;
                end else if (phase == 8) begin
                    back_c   = 24'hffffff;
                    border_c = 24'h000000;
                    normal_c = 24'h000000;
                end
                write_reg(REG_TILE_WIDTH, cur_w);
                write_reg(REG_TILE_HEIGHT, cur_h);
                write_reg(REG_SELECTED, (phase >= 10) ? $urandom_range(0, 1)
                                                      : int'(thick_tbl[phase]));
                write_reg(REG_BACK_COLOR, back_c);
                write_reg(REG_BORDER_COLOR, border_c);
                write_reg(REG_NORMAL_COLOR, normal_c);
                write_reg(REG_SPARE_A, $urandom_range(0, 24'hffffff));
                write_reg(REG_SPARE_B, $urandom_range(0, 24'hffffff));
                cfg_we <= 1'b0;
            end

            if (phase == 1) begin
                send_pixel(0, 0);
                send_pixel(63, 63);
                send_pixel(0, 63);
                send_pixel(63, 0);
                send_pixel(8, 8);
                send_pixel(7, 7);
                send_pixel(7, 8);
                send_pixel(8, 7);
                send_pixel(0, 8);
                send_pixel(1, 8);
                send_pixel(2, 8);
                send_pixel(14, 8);
                send_pixel(15, 8);
                send_pixel(16, 8);
            end else if (phase == 2) begin
                send_pixel(32, 32);
                send_pixel(0, 32);
                send_pixel(1, 32);
                send_pixel(3, 32);
                send_pixel(5, 32);
                send_pixel(31, 0);
                send_pixel(63, 32);
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    if (phase == HOLD_PHASE)
                        hold_request = 1'b1;
                    else if (phase == PAUSE_PHASE)
                        drain_pixels();
                end
                send_pixel(pick_coord(cur_w), pick_coord(cur_h));
            end
        end

        drain_pixels();
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
